/* sv/q15a_pkg.sv */
// ----------------------------------------------------------------------------
// q15a_pkg
// Shared widths, side-band flags and CORDIC angle constants for the Q15
// four-quadrant arctangent pipeline.
// ----------------------------------------------------------------------------
package q15a_pkg;

  // Coordinate and magnitude widths.
  localparam int COORD_W = 16;
  localparam int MAG_W   = 16;
  localparam int R_W     = 15;

  // CORDIC datapath: x and y carry 33 guard bits below the Q15 ratio.
  localparam int CRD_ITERS = 48;
  localparam int XY_SHIFT  = 33;
  localparam int XY_W      = 51;

  // Angle accumulator: 1.0 stands for pi, with ANG_FRAC fraction bits.
  localparam int ANG_FRAC  = 50;
  localparam int ANG_W     = 52;
  localparam int ALPHA_W   = 13;
  localparam int ALPHA_LSB = ANG_FRAC - R_W;

  // Scale from radians to accumulator units.
  localparam real PI_REAL   = $acos(-1.0);
  localparam real ANG_SCALE = (2.0 ** ANG_FRAC) / PI_REAL;

  // Output angle codes.
  localparam logic [R_W-1:0]            HALF_PI_Q15 = 15'd16384;
  localparam logic signed [COORD_W-1:0] PI_Q15      = 16'sd32767;
  localparam logic [R_W-1:0]            RATIO_EQUAL = 15'd32767;

  // Flags that travel with a point through the pipeline.
  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic swap;
    logic zero;
    logic equal;
  } side_t;

  // atan(2^-i) / pi, scaled by 2^ANG_FRAC and rounded.
  function automatic logic signed [ANG_W-1:0] crd_angle(input int i);
    real v;
    v = $atan(2.0 ** (-i)) * ANG_SCALE;
    return ANG_W'(longint'(v));
  endfunction

endpackage

/* sv/q15a_fold.sv */
// ----------------------------------------------------------------------------
// q15a_fold
// Input stage: takes magnitudes, orders them for the octant ratio and
// records signs and the special cases.
// ----------------------------------------------------------------------------
module q15a_fold (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 en,
  input  logic                                 in_vld,
  input  logic signed [q15a_pkg::COORD_W-1:0]  x_coord,
  input  logic signed [q15a_pkg::COORD_W-1:0]  y_coord,
  output logic                                 vld,
  output logic        [q15a_pkg::MAG_W-1:0]    min_mag,
  output logic        [q15a_pkg::MAG_W-1:0]    max_mag,
  output q15a_pkg::side_t                      side
);

  logic                          vld_r;
  logic [q15a_pkg::MAG_W-1:0]    min_r, max_r, min_nxt, max_nxt;
  logic [q15a_pkg::MAG_W-1:0]    ax, ay;
  q15a_pkg::side_t               side_r, side_nxt;

  // Magnitudes; the most negative code becomes 32768.
  always_comb begin
    ax = x_coord[q15a_pkg::COORD_W-1] ? q15a_pkg::MAG_W'(-x_coord) : q15a_pkg::MAG_W'(x_coord);
    ay = y_coord[q15a_pkg::COORD_W-1] ? q15a_pkg::MAG_W'(-y_coord) : q15a_pkg::MAG_W'(y_coord);
    side_nxt.x_neg = x_coord[q15a_pkg::COORD_W-1];
    side_nxt.y_neg = y_coord[q15a_pkg::COORD_W-1];
    side_nxt.swap  = (ay > ax);
    side_nxt.zero  = (ax == '0) && (ay == '0);
    side_nxt.equal = (ax == ay);
    min_nxt = side_nxt.swap ? ax : ay;
    max_nxt = side_nxt.swap ? ay : ax;
  end

  // Valid bit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  // Payload.
  always_ff @(posedge clk) begin
    if (en) begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      side_r <= side_nxt;
    end
  end

  assign vld     = vld_r;
  assign min_mag = min_r;
  assign max_mag = max_r;
  assign side    = side_r;

endmodule

/* sv/q15a_div.sv */
// ----------------------------------------------------------------------------
// q15a_div
// Pipelined restoring divider: one quotient bit per stage gives the Q15
// ratio min * 2^15 / max, truncated toward zero.
// ----------------------------------------------------------------------------
module q15a_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic [q15a_pkg::MAG_W-1:0]         min_mag,
  input  logic [q15a_pkg::MAG_W-1:0]         max_mag,
  input  q15a_pkg::side_t                    in_side,
  output logic                               vld,
  output logic [q15a_pkg::R_W-1:0]           ratio,
  output q15a_pkg::side_t                    side
);

  localparam int N = q15a_pkg::R_W;

  logic                           v_r    [N];
  logic [q15a_pkg::MAG_W-1:0]     rem_r  [N];
  logic [q15a_pkg::MAG_W-1:0]     den_r  [N];
  logic [q15a_pkg::R_W-1:0]       q_r    [N];
  q15a_pkg::side_t                side_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                         v_in;
    logic [q15a_pkg::MAG_W-1:0]   rem_in, den_in;
    logic [q15a_pkg::R_W-1:0]     q_in;
    q15a_pkg::side_t              side_in;
    logic [q15a_pkg::MAG_W:0]     rem2;
    logic                         ge;
    logic [q15a_pkg::MAG_W-1:0]   rem_nxt;

    if (k == 0) begin : g_first
      assign v_in    = in_vld;
      assign rem_in  = min_mag;
      assign den_in  = max_mag;
      assign q_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign den_in  = den_r[k-1];
      assign q_in    = q_r[k-1];
      assign side_in = side_r[k-1];
    end

    // Shift, compare and conditionally subtract.
    always_comb begin
      rem2    = {rem_in, 1'b0};
      ge      = (rem2 >= {1'b0, den_in});
      rem_nxt = ge ? q15a_pkg::MAG_W'(rem2 - {1'b0, den_in}) : q15a_pkg::MAG_W'(rem2);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        den_r[k]  <= den_in;
        q_r[k]    <= {q_in[q15a_pkg::R_W-2:0], ge};
        side_r[k] <= side_in;
      end
    end
  end

  // Equal magnitudes use the fixed ratio just below one.
  assign vld   = v_r[N-1];
  assign ratio = side_r[N-1].equal ? q15a_pkg::RATIO_EQUAL : q_r[N-1];
  assign side  = side_r[N-1];

endmodule

/* sv/q15a_cordic.sv */
// ----------------------------------------------------------------------------
// q15a_cordic
// Vectoring CORDIC, one micro-rotation per stage, turning the Q15 ratio
// into the truncated octant angle in Q15 units of pi.
// ----------------------------------------------------------------------------
module q15a_cordic (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               en,
  input  logic                               in_vld,
  input  logic [q15a_pkg::R_W-1:0]           ratio,
  input  q15a_pkg::side_t                    in_side,
  output logic                               vld,
  output logic [q15a_pkg::ALPHA_W-1:0]       alpha,
  output q15a_pkg::side_t                    side
);

  localparam int N = q15a_pkg::CRD_ITERS;

  logic                                 v_r    [N];
  logic signed [q15a_pkg::XY_W-1:0]     x_r    [N];
  logic signed [q15a_pkg::XY_W-1:0]     y_r    [N];
  logic signed [q15a_pkg::ANG_W-1:0]    z_r    [N];
  q15a_pkg::side_t                      side_r [N];
  logic signed [q15a_pkg::ANG_W-1:0]    z_fin;

  for (genvar i = 0; i < N; i++) begin : g_stage
    localparam logic signed [q15a_pkg::ANG_W-1:0] STEP = q15a_pkg::crd_angle(i);
    logic                               v_in;
    logic signed [q15a_pkg::XY_W-1:0]   x_in, y_in, x_nxt, y_nxt;
    logic signed [q15a_pkg::ANG_W-1:0]  z_in, z_nxt;
    q15a_pkg::side_t                    side_in;

    if (i == 0) begin : g_first
      // Start from the vector (1, ratio) with guard bits.
      assign v_in    = in_vld;
      assign x_in    = q15a_pkg::XY_W'(1) <<< (q15a_pkg::R_W + q15a_pkg::XY_SHIFT);
      assign y_in    = q15a_pkg::XY_W'(ratio) <<< q15a_pkg::XY_SHIFT;
      assign z_in    = '0;
      assign side_in = in_side;
    end else begin : g_next
      assign v_in    = v_r[i-1];
      assign x_in    = x_r[i-1];
      assign y_in    = y_r[i-1];
      assign z_in    = z_r[i-1];
      assign side_in = side_r[i-1];
    end

    // Rotate toward the x axis and accumulate the rotated angle.
    always_comb begin
      if (!y_in[q15a_pkg::XY_W-1]) begin
        x_nxt = x_in + (y_in >>> i);
        y_nxt = y_in - (x_in >>> i);
        z_nxt = z_in + STEP;
      end else begin
        x_nxt = x_in - (y_in >>> i);
        y_nxt = y_in + (x_in >>> i);
        z_nxt = z_in - STEP;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i] <= 1'b0;
      end else if (en) begin
        v_r[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i]    <= x_nxt;
        y_r[i]    <= y_nxt;
        z_r[i]    <= z_nxt;
        side_r[i] <= side_in;
      end
    end
  end

  // Truncate to Q15; a tiny negative residue at ratio zero reads as zero.
  assign z_fin = z_r[N-1];
  assign alpha = z_fin[q15a_pkg::ANG_W-1] ? '0 :
                 z_fin[q15a_pkg::ALPHA_LSB + q15a_pkg::ALPHA_W - 1:q15a_pkg::ALPHA_LSB];
  assign vld   = v_r[N-1];
  assign side  = side_r[N-1];

endmodule

/* sv/q15_atan2_top.sv */
// ----------------------------------------------------------------------------
// q15_atan2_top
// Four-quadrant arctangent of a signed Q15 point, 32767 standing for pi.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, in_x_coord, in_y_coord) takes one
// point per beat; the result channel (out_valid, out_stall, out_angle) gives
// one angle per point, in input order.
// The pipeline is 65 register stages deep: one fold stage, 15 divider stages
// (one quotient bit each), 48 CORDIC stages (one micro-rotation each) and the
// output register. Throughput is one point per cycle while in_stall is low,
// set by the one-step-per-stage divider and CORDIC.
// When the receiver stalls, the result waits in the output register and the
// pipeline keeps moving until a valid point reaches its last stage; only
// then is in_stall raised and the whole pipeline held, so nothing is lost
// or repeated.
// Reset clears every valid bit, out_valid among them, but not the output angle;
// no point is in flight afterward. The origin returns 0.
// ----------------------------------------------------------------------------
module q15_atan2_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [q15a_pkg::COORD_W-1:0]  in_x_coord,
  input  logic signed [q15a_pkg::COORD_W-1:0]  in_y_coord,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [q15a_pkg::COORD_W-1:0]  out_angle
);

  logic                               en;
  logic                               f_vld, d_vld, c_vld;
  logic [q15a_pkg::MAG_W-1:0]         f_min, f_max;
  q15a_pkg::side_t                    f_side, d_side, c_side;
  logic [q15a_pkg::R_W-1:0]           d_ratio;
  logic [q15a_pkg::ALPHA_W-1:0]       c_alpha;
  logic [q15a_pkg::R_W-1:0]           fold_a;
  logic signed [q15a_pkg::COORD_W-1:0] a_s, angle_nxt, angle_r;
  logic                               out_valid_r, out_valid_nxt, load;

  // Hold the pipeline only when its last stage cannot drain.
  assign en       = !(c_vld && out_valid_r && out_stall);
  assign in_stall = !en;

  q15a_fold u_fold (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (in_valid),
    .x_coord (in_x_coord),
    .y_coord (in_y_coord),
    .vld     (f_vld),
    .min_mag (f_min),
    .max_mag (f_max),
    .side    (f_side)
  );

  q15a_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (f_vld),
    .min_mag (f_min),
    .max_mag (f_max),
    .in_side (f_side),
    .vld     (d_vld),
    .ratio   (d_ratio),
    .side    (d_side)
  );

  q15a_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (d_vld),
    .ratio   (d_ratio),
    .in_side (d_side),
    .vld     (c_vld),
    .alpha   (c_alpha),
    .side    (c_side)
  );

  // Mirror across the diagonal, then place in the quadrant.
  always_comb begin
    fold_a = c_side.swap ? q15a_pkg::R_W'(q15a_pkg::HALF_PI_Q15 - q15a_pkg::R_W'(c_alpha))
                         : q15a_pkg::R_W'(c_alpha);
    a_s    = $signed({1'b0, fold_a});
    if (c_side.zero) begin
      angle_nxt = '0;
    end else if (!c_side.x_neg) begin
      angle_nxt = c_side.y_neg ? -a_s : a_s;
    end else begin
      angle_nxt = c_side.y_neg ? a_s - q15a_pkg::PI_Q15 : q15a_pkg::PI_Q15 - a_s;
    end
  end

  // Output register control.
  always_comb begin
    load = en && c_vld;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_angle = angle_r;

  // The input is held back only while a finished beat waits behind a stall.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall && c_vld))
    else $error("input stalled without a blocked result");

  // Results never take the excluded code.
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_angle != 16'sh8000))
    else $error("angle outside the Q15 range");

  // A blocked result is not overwritten by the pipeline.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_angle)))
    else $error("stalled result changed");

endmodule
